FILE: design/onsd_pkg.sv
// Shared constants and config register indexes for the OFDM null symbol detector.
`timescale 1ns / 1ps

package onsd_pkg;

  localparam int WINDOW      = 50;
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_FRAC  = 25;
  localparam int RATIO_BITS  = 8;

  localparam int PTR_W   = $clog2(WINDOW);
  localparam int ACC_W   = LEVEL_FRAC + SAMPLE_BITS;
  localparam int LV_W    = ACC_W - (LEVEL_FRAC - 16);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int K_W     = RATIO_BITS + $clog2(WINDOW);
  localparam int CMP_W   = (SUM_W + 24 > K_W + LV_W) ? SUM_W + 24 : K_W + LV_W;
  localparam int SHIFT_W = 5;
  localparam int FRAME_W = 20;
  localparam int NULL_W  = 16;
  localparam int LIM_W   = NULL_W + 1;
  localparam int CNT_W   = FRAME_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FRAME_W;

  localparam logic [CFG_IDX_W-1:0] REG_DIP_RATIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_RATIO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_LEN    = 3'd4;

  localparam int SHIFT_MIN = 1;
  localparam int SHIFT_MAX = 24;

  localparam int RST_DIP_RATIO   = 128;
  localparam int RST_END_RATIO   = 192;
  localparam int RST_LEVEL_SHIFT = 17;
  localparam int RST_FRAME_LEN   = 196608;
  localparam int RST_NULL_LEN    = 2656;

  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 3 + 1 + 1 + 1 + 16;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: design/onsd_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module onsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ofdm_null_symbol_detector.sv
// Top level of the OFDM null symbol detector: level average, window sum and phase control.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata envelope, s_tuser restart
//  m_*      out  m_tvalid / m_tready    m_tdata phase, null_start, null_end, timeout, level
//  cfg_*    in   cfg_we                 cfg_index, cfg_data
//
// One word per clock in and out while the output is not stalled; each word is worked out
// in the cycle it is accepted and its result sits in the output register the next cycle.
// The delay line lives in a RAM whose read is prefetched at the next ring position.
// rst is synchronous: phase warm-up, level, sum, count and pointer cleared, registers at reset.
// Input is taken whenever the output register is empty or being drained.
`timescale 1ns / 1ps

module ofdm_null_symbol_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [onsd_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] envelope
  input  logic                                s_tuser,   // [0] restart
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [onsd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [2:0] phase, [3] null_start,
                                                         // [4] null_end, [5] timeout,
                                                         // [21:6] level, rest zero
  input  logic                                cfg_we,
  input  logic [onsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [onsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import onsd_pkg::*;

  typedef enum logic [2:0] {
    PH_WARM = 3'd0,
    PH_FILL = 3'd1,
    PH_DIP  = 3'd2,
    PH_END  = 3'd3,
    PH_HOLD = 3'd4
  } phase_t;

  // config
  logic [K_W-1:0]     dip_k;
  logic [K_W-1:0]     end_k;
  logic [SHIFT_W-1:0] level_shift;
  logic [FRAME_W-1:0] frame_len;
  logic [LIM_W-1:0]   end_limit;

  // state
  phase_t             mode, mode_next;
  logic [ACC_W-1:0]   level_acc, level_acc_next;
  logic [SUM_W-1:0]   window_sum, window_sum_next;
  logic [PTR_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]   count, count_next;

  logic [SAMPLE_BITS-1:0] old_env;
  logic                   ram_we;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] env;
  logic                   restart;

  logic                   nstart, nend, tout;

  logic [ACC_W-1:0]   acc0, acc_upd;
  logic [SUM_W-1:0]   sum0, sum_slide;
  logic [PTR_W-1:0]   ptr0, ptr_inc;
  logic [CNT_W-1:0]   cnt0, cnt_inc, cnt_end;
  phase_t             mode0;

  logic [LV_W-1:0]    lv;
  logic [CMP_W-1:0]   sum_scaled, dip_thr, end_thr;
  logic               dip_hit, end_hit;

  logic [SHIFT_W-1:0] cfg_shift;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign env     = s_tdata[SAMPLE_BITS-1:0];
  assign restart = s_tuser;

  // clamp shift on write
  always_comb begin
    cfg_shift = cfg_data[SHIFT_W-1:0];
    if (cfg_shift < SHIFT_W'(SHIFT_MIN)) begin
      cfg_shift = SHIFT_W'(SHIFT_MIN);
    end else if (cfg_shift > SHIFT_W'(SHIFT_MAX)) begin
      cfg_shift = SHIFT_W'(SHIFT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_k       <= K_W'(RST_DIP_RATIO * WINDOW);
      end_k       <= K_W'(RST_END_RATIO * WINDOW);
      level_shift <= SHIFT_W'(RST_LEVEL_SHIFT);
      frame_len   <= FRAME_W'(RST_FRAME_LEN);
      end_limit   <= LIM_W'(RST_NULL_LEN + WINDOW);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIP_RATIO:   dip_k <= K_W'(cfg_data[RATIO_BITS-1:0] * K_W'(WINDOW));
        REG_END_RATIO:   end_k <= K_W'(cfg_data[RATIO_BITS-1:0] * K_W'(WINDOW));
        REG_LEVEL_SHIFT: level_shift <= cfg_shift;
        REG_FRAME_LEN:   frame_len <= cfg_data[FRAME_W-1:0];
        REG_NULL_LEN:    end_limit <= LIM_W'(cfg_data[NULL_W-1:0]) + LIM_W'(WINDOW);
        default: ;
      endcase
    end
  end

  // threshold tests on the state before the word
  assign lv         = level_acc[ACC_W-1:LEVEL_FRAC-16];
  assign sum_scaled = CMP_W'(window_sum) << 24;
  assign dip_thr    = CMP_W'(dip_k) * CMP_W'(lv);
  assign end_thr    = CMP_W'(end_k) * CMP_W'(lv);
  assign dip_hit    = sum_scaled <= dip_thr;
  assign end_hit    = sum_scaled >= end_thr;

  always_comb begin
    acc0  = restart ? '0 : level_acc;
    sum0  = restart ? '0 : window_sum;
    ptr0  = restart ? '0 : ptr;
    cnt0  = restart ? '0 : count;
    mode0 = restart ? PH_WARM : mode;

    acc_upd   = acc0 - (acc0 >> level_shift)
              + (ACC_W'(env) << (SHIFT_W'(LEVEL_FRAC) - level_shift));
    sum_slide = sum0 + SUM_W'(env) - SUM_W'(old_env);
    ptr_inc   = (ptr0 == PTR_W'(WINDOW - 1)) ? '0 : ptr0 + PTR_W'(1);
    cnt_inc   = cnt0 + CNT_W'(1);
    cnt_end   = ((mode0 == PH_DIP) ? '0 : cnt0) + CNT_W'(1);

    mode_next       = mode0;
    level_acc_next  = acc_upd;
    window_sum_next = sum0;
    ptr_next        = ptr0;
    count_next      = cnt0;
    ram_we          = 1'b0;
    nstart          = 1'b0;
    nend            = 1'b0;
    tout            = 1'b0;

    unique case (mode0) inside
      PH_WARM: begin
        if (cnt_inc >= CNT_W'(frame_len)) begin
          mode_next       = PH_FILL;
          count_next      = '0;
          window_sum_next = '0;
          ptr_next        = '0;
        end else begin
          count_next = cnt_inc;
        end
      end
      PH_FILL: begin
        ram_we          = 1'b1;
        window_sum_next = sum0 + SUM_W'(env);
        ptr_next        = ptr_inc;
        if (ptr0 == PTR_W'(WINDOW - 1)) begin
          mode_next  = PH_DIP;
          count_next = '0;
        end
      end
      PH_DIP, PH_END: begin
        if (mode0 == PH_DIP && !dip_hit) begin
          ram_we          = 1'b1;
          window_sum_next = sum_slide;
          ptr_next        = ptr_inc;
          count_next      = cnt_inc;
          if (cnt_inc > CNT_W'(frame_len)) begin
            tout           = 1'b1;
            level_acc_next = '0;
            count_next     = '0;
            mode_next      = PH_WARM;
          end
        end else begin
          nstart = (mode0 == PH_DIP);
          if (end_hit) begin
            nend       = 1'b1;
            mode_next  = PH_HOLD;
            count_next = (mode0 == PH_DIP) ? '0 : cnt0;
          end else begin
            ram_we          = 1'b1;
            window_sum_next = sum_slide;
            ptr_next        = ptr_inc;
            count_next      = cnt_end;
            mode_next       = PH_END;
            if (cnt_end > CNT_W'(end_limit)) begin
              tout           = 1'b1;
              level_acc_next = '0;
              count_next     = '0;
              mode_next      = PH_WARM;
            end
          end
        end
      end
      default: begin
        mode_next = PH_HOLD;
      end
    endcase
  end

  // prefetch the entry the next word will retire
  onsd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_delay (
    .clk  (clk),
    .we   (accept && ram_we),
    .waddr(ptr0),
    .wdata(env),
    .raddr(accept ? ptr_next : ptr),
    .rdata(old_env)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= PH_WARM;
      level_acc  <= '0;
      window_sum <= '0;
      ptr        <= '0;
      count      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        level_acc  <= level_acc_next;
        window_sum <= window_sum_next;
        ptr        <= ptr_next;
        count      <= count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_DATA_W'({level_acc_next[ACC_W-1:LEVEL_FRAC], tout, nend, nstart,
                              mode_next});
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    accept && !restart && mode == PH_FILL && ptr == PTR_W'(WINDOW - 1) |=>
      mode == PH_DIP && ptr == '0)
    else $error("fill did not enter dip search");

  a_timeout_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[2:0] == PH_WARM && m_tdata[21:6] == '0)
    else $error("timeout result not in warm-up with cleared level");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2:0] == PH_END || m_tdata[2:0] == PH_HOLD
      || m_tdata[2:0] == PH_WARM)
    else $error("null start outside end search");

  a_hold_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !restart && mode == PH_HOLD |=> mode == PH_HOLD)
    else $error("hold left without restart");

endmodule

FILE: tb/tb_ofdm_null_symbol_detector.sv
// Self-checking testbench for the OFDM null symbol detector: scripted and random sample streams.
`timescale 1ns / 1ps

module tb_ofdm_null_symbol_detector;
  import onsd_pkg::*;

  localparam int RANDOM_WORDS = 1050;

  typedef enum logic [2:0] {
    ST_WARMUP     = 3'd0,
    ST_FILL       = 3'd1,
    ST_DIP_SEARCH = 3'd2,
    ST_END_SEARCH = 3'd3,
    ST_HOLD       = 3'd4
  } phase_e;

  typedef struct packed {
    logic [2:0]  phase;
    logic        null_start;
    logic        null_end;
    logic        timeout;
    logic [15:0] level;
  } status_t;

  typedef struct packed {
    logic        is_cfg;
    logic [15:0] reps;
    logic [15:0] env;
    logic        restart;
    logic        has_lit;
    status_t     lit;
    logic [7:0]  dip_ratio;
    logic [7:0]  end_ratio;
    logic [4:0]  level_shift;
    logic [19:0] frame_len;
    logic [15:0] null_len;
  } script_row_t;

  localparam script_row_t SCRIPT [22] = '{
    '{reps: 16'd1, env: 16'h0000, has_lit: 1'b1,
      lit: '{ST_WARMUP, 1'b0, 1'b0, 1'b0, 16'd0}, default: 0},
    '{reps: 16'd1, env: 16'hFFFF, has_lit: 1'b1,
      lit: '{ST_WARMUP, 1'b0, 1'b0, 1'b0, 16'd0}, default: 0},
    '{is_cfg: 1'b1, dip_ratio: 8'd128, end_ratio: 8'd192, level_shift: 5'd0,
      frame_len: 20'd0, null_len: 16'd2656, default: 0},
    '{reps: 16'd1, env: 16'hFFFF, restart: 1'b1, has_lit: 1'b1,
      lit: '{ST_FILL, 1'b0, 1'b0, 1'b0, 16'd32767}, default: 0},
    '{reps: 16'd50, env: 16'hFFFF, default: 0},
    '{reps: 16'd1, env: 16'h0000, has_lit: 1'b1,
      lit: '{ST_WARMUP, 1'b0, 1'b0, 1'b1, 16'd0}, default: 0},
    '{reps: 16'd1, env: 16'h0000, has_lit: 1'b1,
      lit: '{ST_FILL, 1'b0, 1'b0, 1'b0, 16'd0}, default: 0},
    '{reps: 16'd50, env: 16'h0000, default: 0},
    '{reps: 16'd1, env: 16'd1234, has_lit: 1'b1,
      lit: '{ST_HOLD, 1'b1, 1'b1, 1'b0, 16'd617}, default: 0},
    '{reps: 16'd1, env: 16'hFFFF, default: 0},
    '{is_cfg: 1'b1, dip_ratio: 8'd255, end_ratio: 8'd255, level_shift: 5'd1,
      frame_len: 20'd0, null_len: 16'd1, default: 0},
    '{reps: 16'd1, env: 16'hFFFF, restart: 1'b1, has_lit: 1'b1,
      lit: '{ST_FILL, 1'b0, 1'b0, 1'b0, 16'd32767}, default: 0},
    '{reps: 16'd50, env: 16'hFFFF, default: 0},
    '{is_cfg: 1'b1, dip_ratio: 8'd255, end_ratio: 8'd255, level_shift: 5'd31,
      frame_len: 20'hFFFFF, null_len: 16'd1, default: 0},
    '{reps: 16'd1, env: 16'h0000, default: 0},
    '{reps: 16'd1, env: 16'h0000, default: 0},
    '{reps: 16'd55, env: 16'h0000, default: 0},
    '{is_cfg: 1'b1, dip_ratio: 8'd0, end_ratio: 8'd0, level_shift: 5'd24,
      frame_len: 20'd1, null_len: 16'hFFFF, default: 0},
    '{reps: 16'd1, env: 16'hFFFF, restart: 1'b1, has_lit: 1'b1,
      lit: '{ST_FILL, 1'b0, 1'b0, 1'b0, 16'd0}, default: 0},
    '{reps: 16'd50, env: 16'd1, default: 0},
    '{reps: 16'd3, env: 16'd5, default: 0},
    '{reps: 16'd1, env: 16'h0000, restart: 1'b1, default: 0}
  };

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic                    s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // detector state mirror
  logic [63:0] lvl_acc;
  logic [63:0] win_sum;
  logic [63:0] scan_cnt;
  logic [15:0] taps [WINDOW];
  int unsigned tap_pos;
  phase_e      cur_phase;
  logic [7:0]  dip_cfg;
  logic [7:0]  end_cfg;
  logic [4:0]  shift_cfg;
  logic [19:0] frame_cfg;
  logic [15:0] null_cfg;

  status_t     due_status [$];
  status_t     status_seen;
  int          errors;
  int unsigned words_sent;
  int unsigned burst_left;

  ofdm_null_symbol_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** ofdm_null_symbol_detector: FAILED **");
    $finish;
  end

  function automatic void blend_level(logic [15:0] env);
    int unsigned s;
    s = (shift_cfg < SHIFT_MIN) ? SHIFT_MIN : (shift_cfg > SHIFT_MAX) ? SHIFT_MAX : shift_cfg;
    lvl_acc = lvl_acc - (lvl_acc >> s) + (64'(env) << (LEVEL_FRAC - s));
  endfunction

  function automatic void slide_window(logic [15:0] env);
    win_sum = win_sum + 64'(env) - 64'(taps[tap_pos]);
    taps[tap_pos] = env;
    tap_pos = (tap_pos + 1 >= WINDOW) ? 0 : tap_pos + 1;
  endfunction

  function automatic void back_to_warmup();
    lvl_acc = '0;
    scan_cnt = '0;
    cur_phase = ST_WARMUP;
  endfunction

  function automatic status_t track_sample(logic [15:0] env, logic restart);
    status_t     r;
    logic [63:0] lv;
    bit          try_end;
    r = '0;
    try_end = 1'b0;
    lv = lvl_acc >> (LEVEL_FRAC - 16);
    if (restart) begin
      back_to_warmup();
      win_sum = '0;
      tap_pos = 0;
      lv = '0;
    end
    case (cur_phase)
      ST_WARMUP: begin
        blend_level(env);
        scan_cnt++;
        if (scan_cnt >= 64'(frame_cfg)) begin
          cur_phase = ST_FILL;
          scan_cnt = '0;
          win_sum = '0;
          tap_pos = 0;
        end
      end
      ST_FILL: begin
        blend_level(env);
        taps[tap_pos] = env;
        win_sum += 64'(env);
        if (tap_pos + 1 >= WINDOW) begin
          tap_pos = 0;
          cur_phase = ST_DIP_SEARCH;
          scan_cnt = '0;
        end else begin
          tap_pos++;
        end
      end
      ST_DIP_SEARCH: begin
        if ((win_sum << 24) <= 64'(dip_cfg) * 64'(WINDOW) * lv) begin
          r.null_start = 1'b1;
          cur_phase = ST_END_SEARCH;
          scan_cnt = '0;
          try_end = 1'b1;
        end else begin
          blend_level(env);
          slide_window(env);
          scan_cnt++;
          if (scan_cnt > 64'(frame_cfg)) begin
            r.timeout = 1'b1;
            back_to_warmup();
          end
        end
      end
      ST_END_SEARCH: try_end = 1'b1;
      default: begin
        cur_phase = ST_HOLD;
        blend_level(env);
      end
    endcase
    if (try_end) begin
      if ((win_sum << 24) >= 64'(end_cfg) * 64'(WINDOW) * lv) begin
        r.null_end = 1'b1;
        cur_phase = ST_HOLD;
        blend_level(env);
      end else begin
        blend_level(env);
        slide_window(env);
        scan_cnt++;
        if (scan_cnt > 64'(null_cfg) + 64'(WINDOW)) begin
          r.timeout = 1'b1;
          back_to_warmup();
        end
      end
    end
    r.phase = cur_phase;
    r.level = lvl_acc[LEVEL_FRAC +: 16];
    return r;
  endfunction

  task automatic push_word(input logic [15:0] env, input logic restart, input bit use_lit,
                           input status_t lit);
    int unsigned gap;
    status_t     guess;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'(env);
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    guess = track_sample(env, restart);
    due_status.push_back(use_lit ? lit : guess);
    words_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_registers(input logic [7:0] dip, input logic [7:0] endr,
                                input logic [4:0] shift, input logic [19:0] frame,
                                input logic [15:0] nul);
    cfg_we <= 1'b1;
    cfg_index <= REG_DIP_RATIO;
    cfg_data <= CFG_DATA_W'(dip);
    @(posedge clk);
    cfg_index <= REG_END_RATIO;
    cfg_data <= CFG_DATA_W'(endr);
    @(posedge clk);
    cfg_index <= REG_LEVEL_SHIFT;
    cfg_data <= CFG_DATA_W'(shift);
    @(posedge clk);
    cfg_index <= REG_FRAME_LEN;
    cfg_data <= CFG_DATA_W'(frame);
    @(posedge clk);
    cfg_index <= REG_NULL_LEN;
    cfg_data <= CFG_DATA_W'(nul);
    @(posedge clk);
    cfg_we <= 1'b0;
    dip_cfg = dip;
    end_cfg = endr;
    shift_cfg = shift;
    frame_cfg = frame;
    null_cfg = nul;
  endtask

  task automatic send_frame();
    int unsigned hi, nspan, t_pre, t_null, t_post, total, cut_at;
    logic [15:0] env;
    hi = $urandom_range(2048, 65535);
    nspan = (null_cfg > 150) ? 150 : null_cfg;
    t_pre = ((frame_cfg == 0) ? 1 : frame_cfg) + WINDOW + $urandom_range(0, 40);
    t_null = t_pre + $urandom_range(nspan / 2 + 20, nspan + 120);
    t_post = t_null + $urandom_range(10, 80);
    total = t_post + $urandom_range(0, 10);
    cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < total; i++) begin
      if (i >= t_post)
        env = 16'($urandom);
      else if (i >= t_pre && i < t_null)
        env = 16'($urandom_range(0, hi / 16));
      else
        env = 16'(hi - $urandom_range(0, hi / 8));
      push_word(env, (i == 0) || (i == cut_at), 1'b0, '0);
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    logic [15:0] env;
    n = $urandom_range(20, 80);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: env = '0;
        1: env = '1;
        default: env = 16'($urandom);
      endcase
      push_word(env, $urandom_range(0, 19) == 0, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_status.size() == 0) begin
        $display("%0t: status word expected none got %h", $time, m_tdata);
        errors++;
      end else begin
        status_seen = due_status.pop_front();
        check_field("phase", 16'(status_seen.phase), 16'(m_tdata[2:0]));
        check_field("null_start", 16'(status_seen.null_start), 16'(m_tdata[3]));
        check_field("null_end", 16'(status_seen.null_end), 16'(m_tdata[4]));
        check_field("timeout", 16'(status_seen.timeout), 16'(m_tdata[5]));
        check_field("level", status_seen.level, m_tdata[21:6]);
      end
    end
  end

  initial begin
    int unsigned style, left, tick;
    m_tready = 1'b0;
    style = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(16, 300);
      end
      left--;
      tick++;
      case (style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 6);
        2: m_tready <= (tick % 4 != 0);
        default: m_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    int unsigned directed_words;
    logic [7:0]  dip, endr;
    logic [4:0]  shift;
    logic [19:0] frame;
    logic [15:0] nul;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    words_sent = 0;
    burst_left = 0;
    dip_cfg = RST_DIP_RATIO;
    end_cfg = RST_END_RATIO;
    shift_cfg = RST_LEVEL_SHIFT;
    frame_cfg = RST_FRAME_LEN;
    null_cfg = RST_NULL_LEN;
    lvl_acc = '0;
    win_sum = '0;
    scan_cnt = '0;
    tap_pos = 0;
    cur_phase = ST_WARMUP;
    foreach (taps[i]) taps[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        drain_results();
        load_registers(SCRIPT[i].dip_ratio, SCRIPT[i].end_ratio, SCRIPT[i].level_shift,
                       SCRIPT[i].frame_len, SCRIPT[i].null_len);
      end else begin
        repeat (SCRIPT[i].reps)
          push_word(SCRIPT[i].env, SCRIPT[i].restart, SCRIPT[i].has_lit, SCRIPT[i].lit);
      end
    end

    directed_words = words_sent;
    while (words_sent - directed_words < RANDOM_WORDS) begin
      drain_results();
      dip = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                        : 8'($urandom_range(96, 230));
      endr = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                         : 8'($urandom_range(120, 255));
      case ($urandom_range(0, 15))
        0: shift = 5'd1;
        1: shift = 5'd24;
        2: shift = 5'd0;
        3: shift = 5'($urandom_range(25, 31));
        default: shift = 5'($urandom_range(4, 6));
      endcase
      frame = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(1, 8))
                                          : 20'($urandom_range(48, 128));
      case ($urandom_range(0, 9))
        0: nul = 16'd1;
        1: nul = 16'($urandom_range(200, 65535));
        default: nul = 16'($urandom_range(10, 80));
      endcase
      load_registers(dip, endr, shift, frame, nul);
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 4) == 0)
          send_noise();
        else
          send_frame();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("** ofdm_null_symbol_detector: PASSED **");
    else
      $display("** ofdm_null_symbol_detector: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
design/onsd_pkg.sv
design/onsd_ram.sv
design/ofdm_null_symbol_detector.sv
tb/tb_ofdm_null_symbol_detector.sv
